[rtl/core/rsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types, command codes and width helpers for the RPN stack ALU.
// ----------------------------------------------------------------------------
package rsa_pkg;

    typedef struct packed {
        logic [5:0]  cmd;
        logic [63:0] operand;
    } t_in_item;

    typedef struct packed {
        logic [63:0] x_value;
        logic [63:0] y_value;
        logic [63:0] z_value;
        logic [63:0] t_value;
        logic [1:0]  width_code;
        logic        divide_by_zero;
    } t_out_item;

    typedef enum logic [1:0] {
        K_SIMPLE,
        K_MUL,
        K_DIV
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  cmd;
        logic [63:0] operand;
    } t_queue_entry;

    localparam logic SIGN_TWOS     = 1'b0;
    localparam logic SIGN_UNSIGNED = 1'b1;

    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;
    localparam logic [1:0] WC_32 = 2'd2;
    localparam logic [1:0] WC_64 = 2'd3;

    localparam logic [5:0] CMD_ENTER  = 6'd0;
    localparam logic [5:0] CMD_OR     = 6'd1;
    localparam logic [5:0] CMD_ORI    = 6'd2;
    localparam logic [5:0] CMD_NOT    = 6'd3;
    localparam logic [5:0] CMD_AND    = 6'd4;
    localparam logic [5:0] CMD_ANDI   = 6'd5;
    localparam logic [5:0] CMD_XOR    = 6'd6;
    localparam logic [5:0] CMD_XORI   = 6'd7;
    localparam logic [5:0] CMD_SETN   = 6'd8;
    localparam logic [5:0] CMD_SETNI  = 6'd9;
    localparam logic [5:0] CMD_CLRN   = 6'd10;
    localparam logic [5:0] CMD_CLRNI  = 6'd11;
    localparam logic [5:0] CMD_RDN    = 6'd12;
    localparam logic [5:0] CMD_RUP    = 6'd13;
    localparam logic [5:0] CMD_SWAP   = 6'd14;
    localparam logic [5:0] CMD_CLX    = 6'd15;
    localparam logic [5:0] CMD_CLALL  = 6'd16;
    localparam logic [5:0] CMD_LDX    = 6'd17;
    localparam logic [5:0] CMD_NEG    = 6'd18;
    localparam logic [5:0] CMD_SHL1   = 6'd19;
    localparam logic [5:0] CMD_SHR1   = 6'd20;
    localparam logic [5:0] CMD_SHL    = 6'd21;
    localparam logic [5:0] CMD_SHLI   = 6'd22;
    localparam logic [5:0] CMD_SHR    = 6'd23;
    localparam logic [5:0] CMD_SHRI   = 6'd24;
    localparam logic [5:0] CMD_ROL1   = 6'd25;
    localparam logic [5:0] CMD_ROR1   = 6'd26;
    localparam logic [5:0] CMD_ROL    = 6'd27;
    localparam logic [5:0] CMD_ROLI   = 6'd28;
    localparam logic [5:0] CMD_ROR    = 6'd29;
    localparam logic [5:0] CMD_RORI   = 6'd30;
    localparam logic [5:0] CMD_ADD    = 6'd31;
    localparam logic [5:0] CMD_ADDI   = 6'd32;
    localparam logic [5:0] CMD_SUB    = 6'd33;
    localparam logic [5:0] CMD_SUBI   = 6'd34;
    localparam logic [5:0] CMD_MUL    = 6'd35;
    localparam logic [5:0] CMD_MULI   = 6'd36;
    localparam logic [5:0] CMD_DIV    = 6'd37;
    localparam logic [5:0] CMD_DIVI   = 6'd38;
    localparam logic [5:0] CMD_MOD    = 6'd39;
    localparam logic [5:0] CMD_MODI   = 6'd40;
    localparam logic [5:0] CMD_DWMUL  = 6'd41;
    localparam logic [5:0] CMD_DWMULI = 6'd42;
    localparam logic [5:0] CMD_SETW   = 6'd43;

    function automatic logic [63:0] mask_w(input logic [1:0] wc);
        logic [63:0] m;
        case (wc)
            WC_8:    m = 64'h0000_0000_0000_00FF;
            WC_16:   m = 64'h0000_0000_0000_FFFF;
            WC_32:   m = 64'h0000_0000_FFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

    function automatic logic [6:0] width_of(input logic [1:0] wc);
        return 7'd8 << wc;
    endfunction

    // sign extend a masked word from the current width to 64 bits
    function automatic logic [63:0] sext_w(input logic [63:0] v, input logic [1:0] wc);
        logic [63:0] s;
        case (wc)
            WC_8:    s = {{56{v[7]}}, v[7:0]};
            WC_16:   s = {{48{v[15]}}, v[15:0]};
            WC_32:   s = {{32{v[31]}}, v[31:0]};
            default: s = v;
        endcase
        return s;
    endfunction

    function automatic logic [63:0] shl_w(input logic [63:0] v, input logic [63:0] n,
                                         input logic [1:0] wc);
        logic [63:0] r;
        if (n >= {57'd0, width_of(wc)}) begin
            r = '0;
        end else begin
            r = (v << n[5:0]) & mask_w(wc);
        end
        return r;
    endfunction

    function automatic logic [63:0] shr_w(input logic [63:0] v, input logic [63:0] n,
                                         input logic [1:0] wc);
        logic [63:0] r;
        if (n >= {57'd0, width_of(wc)}) begin
            r = '0;
        end else begin
            r = (v & mask_w(wc)) >> n[5:0];
        end
        return r;
    endfunction

    // rotate left within the width; count taken mod width
    function automatic logic [63:0] rotl_w(input logic [63:0] v, input logic [5:0] n,
                                          input logic [1:0] wc);
        logic [6:0]  w;
        logic [5:0]  nn;
        logic [63:0] vm;
        w  = width_of(wc);
        nn = n & (w[5:0] - 6'd1);
        vm = v & mask_w(wc);
        return ((vm << nn) | (vm >> (w - {1'b0, nn}))) & mask_w(wc);
    endfunction

    function automatic logic [63:0] rotr_w(input logic [63:0] v, input logic [5:0] n,
                                          input logic [1:0] wc);
        logic [6:0] w;
        logic [5:0] wm1;
        w   = width_of(wc);
        wm1 = w[5:0] - 6'd1;
        return rotl_w(v, (w[5:0] - (n & wm1)) & wm1, wc);
    endfunction

endpackage

[rtl/core/rsa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_front
// Accepts commands, tags each with its execution class and queues it in a
// two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module rsa_front
    import rsa_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  t_in_item     i_in_item,
    output logic         o_in_stall,
    input  logic         i_pop,
    output logic         o_head_valid,
    output t_queue_entry o_head
);

    t_queue_entry r_mem [0:1];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_count;
    logic         push;
    t_kind        kind;

    always_comb begin
        case (i_in_item.cmd)
            CMD_MUL, CMD_MULI, CMD_DWMUL, CMD_DWMULI: kind = K_MUL;
            CMD_DIV, CMD_DIVI, CMD_MOD, CMD_MODI:     kind = K_DIV;
            default:                                  kind = K_SIMPLE;
        endcase
    end

    assign o_in_stall   = (r_count == 2'd2);
    assign push         = i_in_valid && !o_in_stall;
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= '{kind: kind, cmd: i_in_item.cmd, operand: i_in_item.operand};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // pop only from a non-empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("rsa_front: pop from empty queue");

endmodule

[rtl/core/rsa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_back
// Holds the four stack levels and the width, executes one command at a time
// (shift-add multiplier, restoring divider) and registers the result.
// ----------------------------------------------------------------------------
module rsa_back
    import rsa_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_arith_mode,
    input  logic         i_head_valid,
    input  t_queue_entry i_head,
    output logic         o_pop,
    output logic         o_out_valid,
    output t_out_item    o_out_item,
    input  logic         i_out_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MFIX1,
        S_MFIX2,
        S_DIV,
        S_DFIX,
        S_DONE
    } t_state;

    t_state      r_state;
    logic [63:0] r_x, r_y, r_z, r_t;
    logic [1:0]  r_wc;
    logic [5:0]  r_cmd;
    logic [63:0] r_opr;
    logic [63:0] r_a, r_b;
    logic [63:0] r_acc_hi, r_acc_lo;
    logic [5:0]  r_cnt;
    logic        r_dz, r_nx, r_ny, r_mod;
    t_out_item   r_out;
    logic        r_out_valid;

    logic [63:0] n_x, n_y, n_z, n_t;
    logic [1:0]  n_wc;
    logic        n_dz;

    logic        signed_mode;
    logic        out_free;
    logic        commit;
    logic [5:0]  cur_cmd;
    logic [63:0] cur_opr;
    logic [63:0] m, e, res, hi_w;
    logic [6:0]  w7;
    logic        bin;

    logic [63:0] op_a, op_b, ext_a, ext_b;
    logic [63:0] dvd_s, dvs_s, dvd_mag, dvs_mag;
    logic [64:0] mul_sum;
    logic [64:0] rem_sh, rem_diff;
    logic        rem_ge;
    logic [63:0] div_fix;

    assign signed_mode = (i_arith_mode == SIGN_TWOS);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign cur_cmd     = (r_state == S_IDLE) ? i_head.cmd : r_cmd;
    assign cur_opr     = (r_state == S_IDLE) ? i_head.operand : r_opr;
    assign commit      = out_free && ((r_state == S_DONE) ||
                         (r_state == S_IDLE && i_head_valid && i_head.kind == K_SIMPLE));
    assign o_pop       = (r_state == S_IDLE) && i_head_valid &&
                         ((i_head.kind != K_SIMPLE) || out_free);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // operand selection for the long units, taken from the queue head
    always_comb begin
        m     = mask_w(r_wc);
        e     = cur_opr & m;
        op_a  = r_x;
        op_b  = e;
        case (cur_cmd)
            CMD_MUL:   begin op_a = r_y; op_b = r_x; end
            CMD_DWMUL: begin op_a = r_x; op_b = r_y; end
            CMD_DIV:   begin op_a = r_y; op_b = r_x; end
            CMD_MOD:   begin op_a = r_y; op_b = r_x; end
            default:   begin op_a = r_x; op_b = e; end
        endcase
        ext_a   = signed_mode ? sext_w(op_a, r_wc) : op_a;
        ext_b   = signed_mode ? sext_w(op_b, r_wc) : op_b;
        dvd_s   = ext_a;
        dvs_s   = ext_b;
        dvd_mag = (signed_mode && dvd_s[63]) ? (64'd0 - dvd_s) : dvd_s;
        dvs_mag = (signed_mode && dvs_s[63]) ? (64'd0 - dvs_s) : dvs_s;
    end

    // one step of each iterative unit
    always_comb begin
        mul_sum  = {1'b0, r_acc_hi} + (r_acc_lo[0] ? {1'b0, r_b} : 65'd0);
        rem_sh   = {r_acc_hi, r_acc_lo[63]};
        rem_ge   = (rem_sh >= {1'b0, r_b});
        rem_diff = rem_sh - {1'b0, r_b};
    end

    // sign correction of the divider quotient, sign and floor correction of its remainder
    always_comb begin
        if (r_dz) begin
            div_fix = '0;
        end else if (!r_mod) begin
            div_fix = (r_nx != r_ny) ? (64'd0 - r_acc_lo) : r_acc_lo;
        end else if (r_acc_hi == 64'd0) begin
            div_fix = '0;
        end else if (r_nx != r_ny) begin
            div_fix = r_ny ? (r_a - r_acc_hi) : (r_acc_hi + r_a);
        end else begin
            div_fix = r_ny ? (64'd0 - r_acc_hi) : r_acc_hi;
        end
    end

    // high word of the double-width product at the current width
    always_comb begin
        case (r_wc)
            WC_8:    hi_w = {56'd0, r_acc_lo[15:8]};
            WC_16:   hi_w = {48'd0, r_acc_lo[31:16]};
            WC_32:   hi_w = {32'd0, r_acc_lo[63:32]};
            default: hi_w = r_acc_hi;
        endcase
    end

    // next stack contents
    always_comb begin
        w7   = width_of(r_wc);
        n_x  = r_x;
        n_y  = r_y;
        n_z  = r_z;
        n_t  = r_t;
        n_wc = r_wc;
        n_dz = 1'b0;
        res  = '0;
        bin  = 1'b0;
        case (cur_cmd)
            CMD_ENTER:  begin n_t = r_z; n_z = r_y; n_y = r_x; n_x = e; end
            CMD_OR:     begin res = r_x | r_y; bin = 1'b1; end
            CMD_ORI:    n_x = r_x | e;
            CMD_NOT:    n_x = ~r_x;
            CMD_AND:    begin res = r_x & r_y; bin = 1'b1; end
            CMD_ANDI:   n_x = r_x & e;
            CMD_XOR:    begin res = r_x ^ r_y; bin = 1'b1; end
            CMD_XORI:   n_x = r_x ^ e;
            CMD_SETN: begin
                res = (r_x < {57'd0, w7}) ? (r_y | (64'd1 << r_x[5:0])) : r_y;
                bin = 1'b1;
            end
            CMD_SETNI: begin
                if (cur_opr < {57'd0, w7}) begin
                    n_x = r_x | (64'd1 << cur_opr[5:0]);
                end
            end
            CMD_CLRN: begin
                res = (r_x < {57'd0, w7}) ? (r_y & ~(64'd1 << r_x[5:0])) : r_y;
                bin = 1'b1;
            end
            CMD_CLRNI: begin
                if (cur_opr < {57'd0, w7}) begin
                    n_x = r_x & ~(64'd1 << cur_opr[5:0]);
                end
            end
            CMD_RDN:    begin n_x = r_y; n_y = r_z; n_z = r_t; n_t = r_x; end
            CMD_RUP:    begin n_x = r_t; n_y = r_x; n_z = r_y; n_t = r_z; end
            CMD_SWAP:   begin n_x = r_y; n_y = r_x; end
            CMD_CLX:    n_x = '0;
            CMD_CLALL:  begin n_x = '0; n_y = '0; n_z = '0; n_t = '0; end
            CMD_LDX:    n_x = e;
            CMD_NEG:    n_x = 64'd0 - r_x;
            CMD_SHL1:   n_x = shl_w(r_x, 64'd1, r_wc);
            CMD_SHR1:   n_x = shr_w(r_x, 64'd1, r_wc);
            CMD_SHL:    begin res = shl_w(r_y, r_x, r_wc); bin = 1'b1; end
            CMD_SHLI:   n_x = shl_w(r_x, cur_opr, r_wc);
            CMD_SHR:    begin res = shr_w(r_y, r_x, r_wc); bin = 1'b1; end
            CMD_SHRI:   n_x = shr_w(r_x, cur_opr, r_wc);
            CMD_ROL1:   n_x = rotl_w(r_x, 6'd1, r_wc);
            CMD_ROR1:   n_x = rotr_w(r_x, 6'd1, r_wc);
            CMD_ROL:    begin res = rotl_w(r_y, r_x[5:0], r_wc); bin = 1'b1; end
            CMD_ROLI:   n_x = rotl_w(r_x, cur_opr[5:0], r_wc);
            CMD_ROR:    begin res = rotr_w(r_y, r_x[5:0], r_wc); bin = 1'b1; end
            CMD_RORI:   n_x = rotr_w(r_x, cur_opr[5:0], r_wc);
            CMD_ADD:    begin res = r_y + r_x; bin = 1'b1; end
            CMD_ADDI:   n_x = r_x + e;
            CMD_SUB:    begin res = r_y - r_x; bin = 1'b1; end
            CMD_SUBI:   n_x = r_x - e;
            CMD_MUL:    begin res = r_acc_lo; bin = 1'b1; end
            CMD_MULI:   n_x = r_acc_lo;
            CMD_DIV, CMD_MOD: begin res = r_acc_lo; bin = 1'b1; n_dz = r_dz; end
            CMD_DIVI, CMD_MODI: begin n_x = r_acc_lo; n_dz = r_dz; end
            CMD_DWMUL:  begin n_x = r_acc_lo; n_y = hi_w; end
            CMD_DWMULI: begin n_x = r_acc_lo; n_y = hi_w; n_z = r_y; n_t = r_z; end
            CMD_SETW: begin
                if (signed_mode) begin
                    n_x = sext_w(r_x, r_wc);
                    n_y = sext_w(r_y, r_wc);
                    n_z = sext_w(r_z, r_wc);
                    n_t = sext_w(r_t, r_wc);
                end
                n_wc = cur_opr[1:0];
            end
            default: ;
        endcase
        if (bin) begin
            n_x = res;
            n_y = r_z;
            n_z = r_t;
        end
        n_x = n_x & mask_w(n_wc);
        n_y = n_y & mask_w(n_wc);
        n_z = n_z & mask_w(n_wc);
        n_t = n_t & mask_w(n_wc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_x         <= '0;
            r_y         <= '0;
            r_z         <= '0;
            r_t         <= '0;
            r_wc        <= WC_64;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_x         <= n_x;
                r_y         <= n_y;
                r_z         <= n_z;
                r_t         <= n_t;
                r_wc        <= n_wc;
                r_out       <= '{x_value: n_x, y_value: n_y, z_value: n_z, t_value: n_t,
                                 width_code: n_wc, divide_by_zero: n_dz};
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head_valid && i_head.kind == K_MUL) begin
                        r_cmd    <= i_head.cmd;
                        r_opr    <= i_head.operand;
                        r_a      <= ext_a;
                        r_b      <= ext_b;
                        r_acc_lo <= ext_a;
                        r_acc_hi <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_MUL;
                    end else if (i_head_valid && i_head.kind == K_DIV) begin
                        r_cmd    <= i_head.cmd;
                        r_opr    <= i_head.operand;
                        r_a      <= dvs_s;
                        r_b      <= dvs_mag;
                        r_acc_lo <= dvd_mag;
                        r_acc_hi <= '0;
                        r_nx     <= signed_mode && dvs_s[63];
                        r_ny     <= signed_mode && dvd_s[63];
                        r_dz     <= (op_b == 64'd0);
                        r_mod    <= (i_head.cmd == CMD_MOD) || (i_head.cmd == CMD_MODI);
                        r_cnt    <= '0;
                        r_state  <= S_DIV;
                    end
                end
                S_MUL: begin
                    r_acc_hi <= mul_sum[64:1];
                    r_acc_lo <= {mul_sum[0], r_acc_lo[63:1]};
                    r_cnt    <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= S_MFIX1;
                    end
                end
                S_MFIX1: begin
                    if (signed_mode && r_a[63]) begin
                        r_acc_hi <= r_acc_hi - r_b;
                    end
                    r_state <= S_MFIX2;
                end
                S_MFIX2: begin
                    if (signed_mode && r_b[63]) begin
                        r_acc_hi <= r_acc_hi - r_a;
                    end
                    r_state <= S_DONE;
                end
                S_DIV: begin
                    r_acc_hi <= rem_ge ? rem_diff[63:0] : rem_sh[63:0];
                    r_acc_lo <= {r_acc_lo[62:0], rem_ge};
                    r_cnt    <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= S_DFIX;
                    end
                end
                S_DFIX: begin
                    r_acc_lo <= div_fix;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_levels_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_x | r_y | r_z | r_t) & ~mask_w(r_wc)) == 64'd0)
        else $error("rsa_back: stack level wider than word width");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("rsa_back: queue pop outside idle");

    a_stack_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_DIV) |=> $stable(r_x) && $stable(r_wc))
        else $error("rsa_back: stack changed during long operation");

endmodule

[rtl/core/rpn_stack_integer_alu_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_integer_alu_unit
// Four-level RPN stack integer ALU with 8/16/32/64-bit word width.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the input channel (i_in_valid / o_in_stall) as a
//   cmd code plus 64-bit operand. Every command produces one transfer on
//   the output channel (o_out_valid / i_out_stall) carrying the full stack
//   X, Y, Z, T, the width code and the divide-by-zero flag.
//   A two-entry queue sits between the command front end and the execute
//   side, so commands are taken while a result waits on a stalled output.
//   Plain commands (logic, shifts, rotates, add, stack moves, width
//   change) pass through the queue into the result register. Multiply
//   forms run a 1-bit-per-cycle shift-add unit; divide and modulo run a
//   restoring divider. One command executes at a time; throughput is set
//   by the execute side. Output stall: the result register holds, the
//   execute side finishes its current command and waits, and the queue
//   fills, then o_in_stall rises. Reset (synchronous, active low): stack
//   cleared, width 64 bits, signed mode, queue and output emptied. The user
//   must write the arithmetic mode on the cfg port (always ready) only
//   while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rpn_stack_integer_alu_unit
    import rsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_data,
    output logic      o_cfg_ready
);

    logic         r_arith_mode;
    logic         head_valid;
    t_queue_entry head;
    logic         pop;

    // config register: 0 two's complement, 1 unsigned
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arith_mode <= SIGN_TWOS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_arith_mode <= i_cfg_data;
        end
    end

    // front end: accept, classify, queue
    rsa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_stall   (o_in_stall),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // execute side: stack, iterative units, result register
    rsa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_arith_mode (r_arith_mode),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .i_out_stall  (i_out_stall)
    );

endmodule
